// ===== sv/gcb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcb_pkg
// Types and constants shared by the glyph coverage blend block.
// ----------------------------------------------------------------------------
package gcb_pkg;

    // Largest surface dimension the block accepts (default)
    localparam int unsigned MAX_DIM_DEF = 4096;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SURF_WIDTH  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SURF_HEIGHT = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ASCENT      = 8'd7;

    // Register reset values
    localparam logic [31:0] FG_COLOR_RST    = 32'hFFFF_FFFF;
    localparam logic [15:0] CLIP_LEFT_RST   = 16'd0;
    localparam logic [15:0] CLIP_TOP_RST    = 16'd0;
    localparam logic [15:0] CLIP_RIGHT_RST  = 16'd4096;
    localparam logic [15:0] CLIP_BOTTOM_RST = 16'd4096;
    localparam logic [12:0] SURF_WIDTH_RST  = 13'd4096;
    localparam logic [12:0] SURF_HEIGHT_RST = 13'd4096;
    localparam logic [7:0]  ASCENT_RST      = 8'd0;

    // Blend constants
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [15:0] BLEND_ROUND  = 16'd127;

    // Internal coordinate width: covers origin + ascent + offset + row
    localparam int unsigned COORD_W = 20;

    // One input beat
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [7:0]  glyph_dx;
        logic signed [7:0]  glyph_dy;
        logic [7:0]         mask_col;
        logic [7:0]         mask_row;
        logic [7:0]         coverage;
        logic [31:0]        background;
    } gcb_in_t;

    // One result beat
    typedef struct packed {
        logic        write_enable;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] pixel_value;
    } gcb_out_t;

endpackage

// ===== sv/glyph_coverage_blend.sv =====
// ----------------------------------------------------------------------------
// glyph_coverage_blend
// Places one glyph mask sample on the surface, clips it and blends the
// foreground color over the background pixel with its coverage alpha.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one mask sample per beat (gcb_in_t).
//   m_valid/m_ready/m_data return exactly one result beat per sample
//   (gcb_out_t); write_enable low means nothing is written and the other
//   fields are zero.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the registers; cfg_ready
//   is always high. Indexes beyond the ascent register are ignored.
//   The user must write registers only while no sample is in flight; the
//   block itself does not enforce this. One sample is accepted every cycle
//   unless a result waits on a stalled receiver. Three register stages do
//   the work: placement and channel products, then clip compare and
//   channel sums, then the divide by 255 into the output register.
//   When a result waits on a stalled receiver, the whole pipeline holds and
//   s_ready drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   register defaults: white foreground, clip box 0..4096, 4096x4096
//   surface, zero ascent.
// ----------------------------------------------------------------------------
module glyph_coverage_blend #(
    parameter int unsigned MAX_DIM = gcb_pkg::MAX_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gcb_pkg::gcb_in_t                s_data,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output gcb_pkg::gcb_out_t               m_data,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gcb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned CW    = gcb_pkg::COORD_W;
    localparam int unsigned DIM_W = 17;
    localparam logic [DIM_W-1:0] MAX_DIM_L = DIM_W'(MAX_DIM);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]        fg_color_reg,    fg_color_next;
    logic signed [15:0] clip_left_reg,   clip_left_next;
    logic signed [15:0] clip_top_reg,    clip_top_next;
    logic signed [15:0] clip_right_reg,  clip_right_next;
    logic signed [15:0] clip_bottom_reg, clip_bottom_next;
    logic [12:0]        surf_width_reg,  surf_width_next;
    logic [12:0]        surf_height_reg, surf_height_next;
    logic signed [7:0]  ascent_reg,      ascent_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        fg_color_next    = fg_color_reg;
        clip_left_next   = clip_left_reg;
        clip_top_next    = clip_top_reg;
        clip_right_next  = clip_right_reg;
        clip_bottom_next = clip_bottom_reg;
        surf_width_next  = surf_width_reg;
        surf_height_next = surf_height_reg;
        ascent_next      = ascent_reg;
        if (cfg_valid) begin
            case (cfg_index)
                gcb_pkg::REG_FG_COLOR:    fg_color_next    = cfg_data;
                gcb_pkg::REG_CLIP_LEFT:   clip_left_next   = cfg_data[15:0];
                gcb_pkg::REG_CLIP_TOP:    clip_top_next    = cfg_data[15:0];
                gcb_pkg::REG_CLIP_RIGHT:  clip_right_next  = cfg_data[15:0];
                gcb_pkg::REG_CLIP_BOTTOM: clip_bottom_next = cfg_data[15:0];
                gcb_pkg::REG_SURF_WIDTH:  surf_width_next  = cfg_data[12:0];
                gcb_pkg::REG_SURF_HEIGHT: surf_height_next = cfg_data[12:0];
                gcb_pkg::REG_ASCENT:      ascent_next      = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg    <= gcb_pkg::FG_COLOR_RST;
            clip_left_reg   <= gcb_pkg::CLIP_LEFT_RST;
            clip_top_reg    <= gcb_pkg::CLIP_TOP_RST;
            clip_right_reg  <= gcb_pkg::CLIP_RIGHT_RST;
            clip_bottom_reg <= gcb_pkg::CLIP_BOTTOM_RST;
            surf_width_reg  <= gcb_pkg::SURF_WIDTH_RST;
            surf_height_reg <= gcb_pkg::SURF_HEIGHT_RST;
            ascent_reg      <= gcb_pkg::ASCENT_RST;
        end else begin
            fg_color_reg    <= fg_color_next;
            clip_left_reg   <= clip_left_next;
            clip_top_reg    <= clip_top_next;
            clip_right_reg  <= clip_right_next;
            clip_bottom_reg <= clip_bottom_next;
            surf_width_reg  <= surf_width_next;
            surf_height_reg <= surf_height_next;
            ascent_reg      <= ascent_next;
        end
    end

    // ------------------------------------------------------------------
    // Effective clip window, registered (the user keeps config static while busy; not enforced)
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]    w_sat, h_sat;
    logic signed [CW-1:0] w_s, h_s, cr_s, cb_s;
    logic signed [CW-1:0] x1_next, y1_next, x2_next, y2_next;
    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;

    always_comb begin
        w_sat   = (DIM_W'(surf_width_reg) > MAX_DIM_L) ? MAX_DIM_L : DIM_W'(surf_width_reg);
        h_sat   = (DIM_W'(surf_height_reg) > MAX_DIM_L) ? MAX_DIM_L : DIM_W'(surf_height_reg);
        w_s     = signed'(CW'(w_sat));
        h_s     = signed'(CW'(h_sat));
        cr_s    = CW'(clip_right_reg);
        cb_s    = CW'(clip_bottom_reg);
        x1_next = clip_left_reg[15] ? '0 : CW'(clip_left_reg);
        y1_next = clip_top_reg[15]  ? '0 : CW'(clip_top_reg);
        x2_next = (cr_s > w_s) ? w_s : cr_s;
        y2_next = (cb_s > h_s) ? h_s : cb_s;
    end

    always_ff @(posedge aclk) begin
        x1_reg <= x1_next;
        y1_reg <= y1_next;
        x2_reg <= x2_next;
        y2_reg <= y2_next;
    end

    // ------------------------------------------------------------------
    // Pipeline advance: all stages move together when the output is free
    // ------------------------------------------------------------------
    logic adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    assign adv     = !s3_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: placement and per-channel products
    // ------------------------------------------------------------------
    logic signed [CW-1:0] px_next, py_next, px1_reg, py1_reg;
    logic [7:0]           inv_a;
    logic [15:0]          pfg_next [3];
    logic [15:0]          pbg_next [3];
    logic [15:0]          pfg1_reg [3];
    logic [15:0]          pbg1_reg [3];
    logic [7:0]           a1_reg;

    always_comb begin
        px_next = CW'(s_data.origin_x) + CW'(s_data.glyph_dx)
                + signed'(CW'(s_data.mask_col));
        py_next = CW'(s_data.origin_y) + CW'(ascent_reg) + CW'(s_data.glyph_dy)
                + signed'(CW'(s_data.mask_row));
        inv_a   = gcb_pkg::ALPHA_OPAQUE - s_data.coverage;
        for (int c = 0; c < 3; c++) begin
            pfg_next[c] = 16'(fg_color_reg[8*c +: 8]) * 16'(s_data.coverage);
            pbg_next[c] = 16'(s_data.background[8*c +: 8]) * 16'(inv_a);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px1_reg <= px_next;
            py1_reg <= py_next;
            a1_reg  <= s_data.coverage;
            for (int c = 0; c < 3; c++) begin
                pfg1_reg[c] <= pfg_next[c];
                pbg1_reg[c] <= pbg_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clip test and rounded channel sums
    // ------------------------------------------------------------------
    logic        in_clip;
    logic        we_next, we2_reg, opaque2_reg;
    logic [15:0] sum_next [3];
    logic [15:0] sum2_reg [3];
    logic [11:0] px2_reg, py2_reg;

    always_comb begin
        in_clip = (px1_reg >= x1_reg) && (px1_reg < x2_reg)
               && (py1_reg >= y1_reg) && (py1_reg < y2_reg);
        we_next = (a1_reg != 8'd0) && in_clip;
        // max sum is 255*255 + 127, fits 16 bits
        for (int c = 0; c < 3; c++) begin
            sum_next[c] = pfg1_reg[c] + pbg1_reg[c] + gcb_pkg::BLEND_ROUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            we2_reg     <= we_next;
            opaque2_reg <= (a1_reg == gcb_pkg::ALPHA_OPAQUE);
            px2_reg     <= px1_reg[11:0];
            py2_reg     <= py1_reg[11:0];
            for (int c = 0; c < 3; c++) begin
                sum2_reg[c] <= sum_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by 255, select the pixel, output register
    // ------------------------------------------------------------------
    logic [16:0]       quo [3];
    logic [31:0]       blend_val;
    gcb_pkg::gcb_out_t out_next, out3_reg;

    always_comb begin
        // exact floor(v/255) for v up to 255*255 + 127, the largest sum
        for (int c = 0; c < 3; c++) begin
            quo[c] = (17'(sum2_reg[c]) + 17'd1 + 17'(sum2_reg[c][15:8])) >> 8;
        end
        blend_val = {gcb_pkg::ALPHA_OPAQUE, quo[2][7:0], quo[1][7:0], quo[0][7:0]};
        out_next  = '0;
        if (we2_reg) begin
            out_next.write_enable = 1'b1;
            out_next.pixel_x      = px2_reg;
            out_next.pixel_y      = py2_reg;
            out_next.pixel_value  = opaque2_reg ? fg_color_reg : blend_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out3_reg <= out_next;
        end
    end

    assign m_data = out3_reg;

endmodule
